@@ rtl/core/rmmm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the running min/max/mean monitor.
// No dependencies; every other file of the block imports this package.
package rmmm_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int VALUE_W      = 32;
  localparam int CLASS_W      = 3;
  localparam int INTERVAL_W   = 16;
  localparam int COUNT_W      = 32;
  localparam int SUM_W        = 64;
  localparam int DIV_STEPS    = SUM_W;
  localparam int STEP_W       = $clog2(DIV_STEPS);

  localparam logic [VALUE_W-1:0] SAMPLE_MASK =
    VALUE_W'((65'd1 << SAMPLE_WIDTH) - 65'd1);
  localparam logic [COUNT_W-1:0]    COUNT_LIMIT    = '1;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_INTERVAL = 1'b0,
    REG_UNUSED   = 1'b1
  } rmmm_reg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } rmmm_cmd_t;

  typedef struct packed {
    logic report;
  } rmmm_sts_t;

endpackage

@@ rtl/core/running_min_max_mean_monitor.sv @@
`timescale 1ns / 1ps
// Top level of the running min/max/mean monitor with its register port.
// Depends on rmmm_pkg, rmmm_ctrl and rmmm_dp.
//
// Each input word carries a cycle count and a class tag. The block keeps a
// saturating item count, a 64-bit running sum and the running minimum and
// maximum, and after every report_interval words it emits one output word with
// the count, the last value, the minimum, the maximum, the truncated mean and
// the tag. A word that does not trigger a report is taken without a stall, so
// such words may arrive back to back. A word that triggers a report holds
// in_stall high through the division and the output load: the mean comes from a
// restoring divider that retires one quotient bit per cycle over the 64-bit
// sum, followed by a state that loads the output register. The output register
// is separate from the intake, so new words are taken while a report waits on
// out_stall; only a second report that finds the output register still full
// waits for it to drain. Once the item count reaches its maximum, the count
// and the sum hold while the minimum and maximum keep tracking. The register
// report_interval (byte address 0, reset value 10) is meant to be written only
// while the block is idle; writing 0 makes every word report.
module running_min_max_mean_monitor
  import rmmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_W-1:0]    in_cycle_count,
  input  logic [CLASS_W-1:0]    in_activity_class,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COUNT_W-1:0]    out_item_total,
  output logic [VALUE_W-1:0]    out_last_value,
  output logic [VALUE_W-1:0]    out_min_value,
  output logic [VALUE_W-1:0]    out_max_value,
  output logic [VALUE_W-1:0]    out_mean_value,
  output logic [CLASS_W-1:0]    out_report_class,
  // Register port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  rmmm_cmd_t             cmd;
  rmmm_sts_t             sts;
  logic [INTERVAL_W-1:0] report_interval_r;
  rmmm_reg_t             reg_sel;

  // Registers sit on 32-bit word boundaries, so the low two address bits
  // do not take part in the decode.
  assign reg_sel = rmmm_reg_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_interval_r <= INTERVAL_RESET;
    end else if (psel && penable && pwrite && (reg_sel == REG_INTERVAL)) begin
      report_interval_r <= pwdata[INTERVAL_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_INTERVAL: prdata = APB_DATA_W'(report_interval_r);
      default:      prdata = '0;
    endcase
  end

  // The controller only sequences; all arithmetic lives in the datapath.
  rmmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rmmm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_cycle_count    (in_cycle_count),
    .in_activity_class (in_activity_class),
    .report_interval   (report_interval_r),
    .out_item_total    (out_item_total),
    .out_last_value    (out_last_value),
    .out_min_value     (out_min_value),
    .out_max_value     (out_max_value),
    .out_mean_value    (out_mean_value),
    .out_report_class  (out_report_class)
  );

endmodule

@@ rtl/core/rmmm_dp.sv @@
`timescale 1ns / 1ps
// Datapath: running statistics, a bit-serial 64 by 32 divider and the output word register.
// Depends on rmmm_pkg; steered by rmmm_ctrl through command and status structs.
module rmmm_dp
  import rmmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  rmmm_cmd_t             cmd,
  output rmmm_sts_t             sts,
  input  logic [VALUE_W-1:0]    in_cycle_count,
  input  logic [CLASS_W-1:0]    in_activity_class,
  input  logic [INTERVAL_W-1:0] report_interval,
  output logic [COUNT_W-1:0]    out_item_total,
  output logic [VALUE_W-1:0]    out_last_value,
  output logic [VALUE_W-1:0]    out_min_value,
  output logic [VALUE_W-1:0]    out_max_value,
  output logic [VALUE_W-1:0]    out_mean_value,
  output logic [CLASS_W-1:0]    out_report_class
);

  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [VALUE_W-1:0]    min_r, min_nxt;
  logic [VALUE_W-1:0]    max_r, max_nxt;
  logic [INTERVAL_W-1:0] ivl_r, ivl_nxt;
  logic [VALUE_W-1:0]    sample_r;
  logic [CLASS_W-1:0]    class_r;
  logic [VALUE_W-1:0]    sample;
  logic [INTERVAL_W:0]   ivl_inc;

  // Divider state: dq_r starts as the dividend and fills with quotient bits.
  logic [SUM_W-1:0]      dq_r;
  logic [VALUE_W-1:0]    rem_r;
  logic [COUNT_W-1:0]    divisor_r;
  logic [VALUE_W:0]      rem_sh;
  logic                  rem_ge;

  assign sample  = in_cycle_count & SAMPLE_MASK;
  assign ivl_inc = {1'b0, ivl_r} + (INTERVAL_W+1)'(1);

  // A zero interval behaves as one, which the >= compare gives for free.
  assign sts.report = (ivl_inc >= {1'b0, report_interval});

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (count_r != COUNT_LIMIT) begin
      count_nxt = count_r + COUNT_W'(1);
      sum_nxt   = sum_r + SUM_W'(sample);
    end
    min_nxt = (sample < min_r) ? sample : min_r;
    max_nxt = (sample > max_r) ? sample : max_r;
    ivl_nxt = sts.report ? '0 : ivl_inc[INTERVAL_W-1:0];
  end

  assign rem_sh = {rem_r, dq_r[SUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, divisor_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      min_r   <= '1;
      max_r   <= '0;
      ivl_r   <= '0;
    end else if (cmd.load) begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      ivl_r   <= ivl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r  <= sample;
      class_r   <= in_activity_class;
      dq_r      <= sum_nxt;
      rem_r     <= '0;
      divisor_r <= count_nxt;
    end else if (cmd.step) begin
      dq_r  <= {dq_r[SUM_W-2:0], rem_ge};
      rem_r <= rem_ge ? VALUE_W'(rem_sh - {1'b0, divisor_r}) : rem_sh[VALUE_W-1:0];
    end
    if (cmd.out_load) begin
      out_item_total   <= count_r;
      out_last_value   <= sample_r;
      out_min_value    <= min_r;
      out_max_value    <= max_r;
      // The mean never exceeds the maximum, so the upper quotient bits are zero.
      out_mean_value   <= dq_r[VALUE_W-1:0];
      out_report_class <= class_r;
    end
  end

endmodule

@@ rtl/core/rmmm_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: sequences word intake, the division steps and the output handshake.
// Depends on rmmm_pkg; drives rmmm_dp through command and status structs.
module rmmm_ctrl
  import rmmm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  rmmm_sts_t sts,
  output rmmm_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               in_stall_r, in_stall_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    in_stall_nxt  = in_stall_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.report) begin
            state_nxt    = ST_DIV;
            step_nxt     = '0;
            in_stall_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
          in_stall_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt    = ST_IDLE;
        in_stall_nxt = 1'b0;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/rmmm_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for the running min/max/mean monitor, bound to the top level.
// Depends on rmmm_pkg and running_min_max_mean_monitor.
module rmmm_chk
  import rmmm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COUNT_W-1:0] out_item_total,
  input logic [VALUE_W-1:0] out_last_value,
  input logic [VALUE_W-1:0] out_min_value,
  input logic [VALUE_W-1:0] out_max_value,
  input logic [VALUE_W-1:0] out_mean_value,
  input logic [CLASS_W-1:0] out_report_class
);

  // A stalled report word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item_total) &&
      $stable(out_last_value) && $stable(out_min_value) &&
      $stable(out_max_value) && $stable(out_mean_value) &&
      $stable(out_report_class))
    else $error("report word changed while stalled");

  // The mean and the triggering value lie between the minimum and the maximum.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_value <= out_mean_value) &&
      (out_mean_value <= out_max_value) &&
      (out_min_value <= out_last_value) && (out_last_value <= out_max_value))
    else $error("report statistics out of order");

  // A report always follows at least one counted word.
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item_total != '0)
    else $error("report with zero item total");

  // Reset leaves the block empty and ready for words.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind running_min_max_mean_monitor rmmm_chk u_rmmm_chk (.*);
